[rtl/sss_pkg.sv]
// Shared types and constants for the smooth size search block.
package sss_pkg;

	// Width of the factor limit register and of a trial factor.
	localparam int unsigned LIMIT_W = 4;

	// Factor limit after reset.
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd7;

	// First odd trial factor.
	localparam logic [LIMIT_W:0] FIRST_ODD_FACTOR = 5'd3;

	// The power of two wins when it exceeds the found size by less than 1/33 of it.
	localparam int unsigned MARGIN_W = 6;
	localparam logic [MARGIN_W-1:0] POW2_MARGIN = 6'd33;

	// Request to the shared trial division unit.
	typedef struct packed {
		logic               load;
		logic [LIMIT_W-1:0] divisor;
	} sss_div_req_t;

endpackage

[rtl/smooth_size_search.sv]
// Top level of the smooth size search block: sequencer, registers and handshakes.
// Sequence: a target at or below the limit, or a limit below two, goes straight to the
// output register; a limit of two runs the power of two search alone. Otherwise each even
// candidate has its factors of two stripped and is trial divided by odd factors up to the
// limit; the first smooth one takes the power of two search, margin check and output register.
// Throughput: one item at a time; the input stalls until the result enters the output register.
// Reset: arst_n clears the sequencer and the output valid and sets the factor limit to 7.
module smooth_size_search #(
	parameter int unsigned SIZE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write channel carrying the factor limit.
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sss_pkg::LIMIT_W-1:0]       factor_limit,
	// Input item channel.
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [SIZE_BITS-1:0]              target_size,
	// Result item channel.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [SIZE_BITS:0]                chosen_size
);
	import sss_pkg::*;

	// Candidates and powers of two never exceed 2^SIZE_BITS.
	localparam int unsigned W = SIZE_BITS + 1;
	localparam int unsigned CMP_W = W + MARGIN_W;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_STRIP = 7'b0000010,
		S_KTEST = 7'b0000100,
		S_CHECK = 7'b0001000,
		S_POW   = 7'b0010000,
		S_CMP   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t             state_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [W-1:0]       cand_q;
	logic [W-1:0]       res_q;
	logic [W-1:0]       pow_q;
	logic [W-1:0]       result_q;
	logic [LIMIT_W:0]   k_q;
	logic               pow_only_q;
	logic               out_valid_q;
	logic [W-1:0]       chosen_q;

	logic               in_accept;
	logic               out_free;
	logic [LIMIT_W:0]   limit_ext;
	logic               res_is_one;
	logic               k_beyond;
	logic [W-1:0]       cand_next;
	logic [W-1:0]       pow_gap;
	logic [CMP_W-1:0]   gap_scaled;
	sss_div_req_t       div_req;
	logic [W-1:0]       div_quot;
	logic               div_hit;

	// Users change the limit only while idle (unenforced); it is always writable.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= factor_limit;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign chosen_size = chosen_q;
	// The output register can take a new result when it is empty or being drained.
	assign out_free  = !out_valid_q || !out_stall;

	assign limit_ext  = {1'b0, limit_q};
	assign res_is_one = (res_q == W'(1));
	assign k_beyond   = (k_q > limit_ext);
	assign cand_next  = cand_q + W'(2);

	// The power of two is taken when (pow - cand) * 33 < cand.
	assign pow_gap    = pow_q - cand_q;
	assign gap_scaled = CMP_W'(pow_gap) * CMP_W'(POW2_MARGIN);

	// A trial division is issued when the residue is above one and factors remain.
	assign div_req.load    = (state_q == S_KTEST) && !res_is_one && !k_beyond;
	assign div_req.divisor = k_q[LIMIT_W-1:0];

	sss_div #(
		.VALUE_W (W)
	) u_div (
		.clk       (clk),
		.req       (div_req),
		.value     (res_q),
		.quotient  (div_quot),
		.divisible (div_hit)
	);

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						if ((W'(target_size) <= W'(limit_q)) || (limit_q < LIMIT_W'(2))) begin
							state_q <= S_DONE;
						end else if (limit_q == LIMIT_W'(2)) begin
							state_q <= S_POW;
						end else begin
							state_q <= S_STRIP;
						end
					end
				end
				S_STRIP: begin
					if (res_q[0] || res_is_one) begin
						state_q <= S_KTEST;
					end
				end
				S_KTEST: begin
					if (res_is_one) begin
						state_q <= S_POW;
					end else if (k_beyond) begin
						state_q <= S_STRIP;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= S_KTEST;
				end
				S_POW: begin
					if (pow_q >= cand_q) begin
						state_q <= pow_only_q ? S_DONE : S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers of the search.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				pow_q <= W'(1);
				k_q   <= FIRST_ODD_FACTOR;
				if (W'(target_size) <= W'(limit_q)) begin
					result_q <= W'(target_size);
				end else begin
					result_q <= '0;
				end
				pow_only_q <= (limit_q == LIMIT_W'(2));
				if (limit_q == LIMIT_W'(2)) begin
					cand_q <= W'(target_size);
				end else begin
					// Round an odd target up to the next even candidate.
					cand_q <= W'(target_size) + W'(target_size[0]);
					res_q  <= W'(target_size) + W'(target_size[0]);
				end
			end
			S_STRIP: begin
				if (!res_q[0] && !res_is_one) begin
					res_q <= res_q >> 1;
				end
			end
			S_KTEST: begin
				if (!res_is_one && k_beyond) begin
					// Not smooth: move to the next even candidate.
					cand_q <= cand_next;
					res_q  <= cand_next;
					k_q    <= FIRST_ODD_FACTOR;
				end
			end
			S_CHECK: begin
				if (div_hit) begin
					res_q <= div_quot;
				end else begin
					k_q <= k_q + (LIMIT_W + 1)'(2);
				end
			end
			S_POW: begin
				if (pow_q < cand_q) begin
					pow_q <= pow_q << 1;
				end else begin
					result_q <= pow_q;
				end
			end
			S_CMP: begin
				if (gap_scaled < CMP_W'(cand_q)) begin
					result_q <= pow_q;
				end else begin
					result_q <= cand_q;
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// Output register: holds the result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			chosen_q <= result_q;
		end
	end

endmodule

[rtl/sss_div.sv]
// Shared trial division unit: exact quotient by a small odd factor and a divisibility flag.
module sss_div #(
	parameter int unsigned VALUE_W = 17
) (
	input  logic                  clk,
	input  sss_pkg::sss_div_req_t req,
	input  logic [VALUE_W-1:0]    value,
	output logic [VALUE_W-1:0]    quotient,
	output logic                  divisible
);
	import sss_pkg::*;

	// Reciprocals are rounded up with SHIFT fraction bits, enough for an exact quotient.
	localparam int unsigned SHIFT = VALUE_W + LIMIT_W;
	localparam int unsigned PROD_W = VALUE_W + SHIFT;
	localparam int unsigned CHK_W = VALUE_W + LIMIT_W;
	localparam longint unsigned ONE_S = 64'd1 << SHIFT;

	localparam logic [SHIFT-1:0] RECIP [16] = '{
		SHIFT'(0), SHIFT'(0), SHIFT'(0),
		SHIFT'((ONE_S + 64'd2) / 64'd3),
		SHIFT'(0),
		SHIFT'((ONE_S + 64'd4) / 64'd5),
		SHIFT'(0),
		SHIFT'((ONE_S + 64'd6) / 64'd7),
		SHIFT'(0),
		SHIFT'((ONE_S + 64'd8) / 64'd9),
		SHIFT'(0),
		SHIFT'((ONE_S + 64'd10) / 64'd11),
		SHIFT'(0),
		SHIFT'((ONE_S + 64'd12) / 64'd13),
		SHIFT'(0),
		SHIFT'((ONE_S + 64'd14) / 64'd15)
	};

	logic [PROD_W-1:0]  prod;
	logic [VALUE_W-1:0] quot_s1;
	logic [VALUE_W-1:0] value_s1;
	logic [LIMIT_W-1:0] div_s1;
	logic [CHK_W-1:0]   back_prod;

	assign prod = PROD_W'(value) * PROD_W'(RECIP[req.divisor]);

	always_ff @(posedge clk) begin
		if (req.load) begin
			quot_s1  <= prod[PROD_W-1:SHIFT];
			value_s1 <= value;
			div_s1   <= req.divisor;
		end
	end

	// The quotient is exact; multiplying back tells whether the remainder was zero.
	assign back_prod = CHK_W'(quot_s1) * CHK_W'(div_s1);
	assign divisible = (back_prod == CHK_W'(value_s1));
	assign quotient  = quot_s1;

endmodule
